/* sv/sle_pkg.sv */
// shared character codes, prompt text and output-word types for the serial line editor
`timescale 1ns / 1ps

package sle_pkg;

    // terminal control and character codes
    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TILDE = 8'h7E;
    localparam logic [7:0] CH_DEL   = 8'h7F;

    // where a result word goes
    localparam logic DEST_ECHO = 1'b0;
    localparam logic DEST_LINE = 1'b1;

    // prompt printed after every line end
    localparam int PROMPT_LEN = 8;
    localparam logic [7:0] PROMPT_BYTES [PROMPT_LEN] = '{
        8'h6C, 8'h61, 8'h6D, 8'h70, 8'h73, 8'h68, 8'h3E, 8'h20
    };

    // one result word as held in the output register
    typedef struct packed {
        logic       dest;
        logic [7:0] data;
        logic       line_end;
        logic       run_last;
    } t_out_word;

endpackage

/* sv/sle_ram.sv */
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps

module sle_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* sv/serial_line_editor.sv */
// serial line editor top level: echo, line assembly and line hand-out
`timescale 1ns / 1ps

// Takes bytes received from a terminal on the slave stream and answers on the
// master stream with echo words (tuser destination 0) and the words of a
// completed command line (destination 1). A tab counts as a space, a second
// space in a row is dropped, backspace or DEL erases one stored byte and
// echoes backspace, space, backspace, and CR or LF ends the line: CR LF is
// echoed, the stored line is handed out with line_end on its last byte, then
// the prompt is echoed. LF right after CR is swallowed. tlast marks the last
// word caused by one input byte. The line lives in a one-port-write,
// one-port-read ram of LINE_MAX bytes; fill count and previous byte sit in
// flip-flops. One input byte is worked on at a time and the next is taken
// only when its words are all placed in the output register. A line end
// steps through S_LREAD and S_LEMIT once per stored byte, because every
// line byte needs its own ram read before it can be loaded into the
// output register; stalls on the master side hold the words back. The
// ram needs no clearing pass: only entries below the fill count are ever
// read, and writes (on input accept) never overlap line reads.
module serial_line_editor #(
    parameter int LINE_MAX = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] rx_byte
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] data_byte
    output logic [1:0] m_axis_tuser,   // [0] destination, [1] line_end
    output logic       m_axis_tlast    // run_last
);

    import sle_pkg::*;

    localparam int AW = (LINE_MAX > 1) ? $clog2(LINE_MAX) : 1;
    localparam int CW = $clog2(LINE_MAX + 1);
    localparam logic [CW-1:0] FILL_MAX = CW'(LINE_MAX);
    localparam logic [2:0] PROMPT_LAST = 3'(PROMPT_LEN - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_ECHO,
        S_CRLF,
        S_LREAD,
        S_LEMIT,
        S_PROMPT,
        S_ERASE
    } t_state;

    // control and line state
    t_state        r_state, n_state;
    logic [2:0]    r_pos, n_pos;       // word index inside crlf, prompt or erase
    logic [CW-1:0] r_idx, n_idx;       // line byte being handed out
    logic [CW-1:0] r_fill, n_fill;     // stored byte count
    logic [7:0]    r_prev, n_prev;     // last byte kept, after tab mapping
    logic [7:0]    r_byte, n_byte;     // byte waiting to be echoed

    // output register
    logic          r_out_valid, n_out_valid;
    t_out_word     r_out, n_out;

    // ram side
    logic          ram_we;
    logic          ram_re;
    logic [7:0]    ram_rdata;

    // input decode
    logic          in_accept;
    logic [7:0]    c;
    logic          is_drop, is_eol, is_print, is_erase;
    logic          out_free;
    logic [CW-1:0] idx_inc;
    logic          line_last;

    assign s_axis_tready = (r_state == S_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    assign c        = (s_axis_tdata == CH_TAB) ? CH_SPACE : s_axis_tdata;
    assign is_drop  = (c == CH_LF) && (r_prev == CH_CR);
    assign is_eol   = (c == CH_CR) || (c == CH_LF);
    assign is_print = (c >= CH_SPACE) && (c <= CH_TILDE)
                      && !((r_prev == CH_SPACE) && (c == CH_SPACE));
    assign is_erase = ((c == CH_BS) || (c == CH_DEL)) && (r_fill != '0);

    // output register can take a word this cycle
    assign out_free  = !r_out_valid || m_axis_tready;
    assign idx_inc   = r_idx + CW'(1);
    assign line_last = (idx_inc == r_fill);

    sle_ram #(
        .WIDTH (8),
        .DEPTH (LINE_MAX)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_fill[AW-1:0]),
        .i_wdata (c),
        .i_re    (ram_re),
        .i_raddr (r_idx[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_state     = r_state;
        n_pos       = r_pos;
        n_idx       = r_idx;
        n_fill      = r_fill;
        n_prev      = r_prev;
        n_byte      = r_byte;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        ram_we      = 1'b0;
        ram_re      = 1'b0;

        // word taken downstream
        if (r_out_valid && m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_accept && !is_drop) begin
                    n_prev = c;
                    if (is_eol) begin
                        n_state = S_CRLF;
                        n_pos   = '0;
                    end else if (is_print) begin
                        n_byte  = c;
                        n_state = S_ECHO;
                        // full line: echo only
                        if (r_fill < FILL_MAX) begin
                            ram_we = 1'b1;
                            n_fill = r_fill + CW'(1);
                        end
                    end else if (is_erase) begin
                        n_fill  = r_fill - CW'(1);
                        n_state = S_ERASE;
                        n_pos   = '0;
                    end
                end
            end
            S_ECHO: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out       = '{dest: DEST_ECHO, data: r_byte,
                                    line_end: 1'b0, run_last: 1'b1};
                    n_state     = S_IDLE;
                end
            end
            S_CRLF: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out       = '{dest: DEST_ECHO,
                                    data: (r_pos == '0) ? CH_CR : CH_LF,
                                    line_end: 1'b0, run_last: 1'b0};
                    if (r_pos == '0) begin
                        n_pos = 3'd1;
                    end else if (r_fill == '0) begin
                        // empty line goes straight to the prompt
                        n_state = S_PROMPT;
                        n_pos   = '0;
                    end else begin
                        n_state = S_LREAD;
                        n_idx   = '0;
                    end
                end
            end
            S_LREAD: begin
                ram_re  = 1'b1;
                n_state = S_LEMIT;
            end
            S_LEMIT: begin
                // read data holds until the next read is issued
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out       = '{dest: DEST_LINE, data: ram_rdata,
                                    line_end: line_last, run_last: 1'b0};
                    if (line_last) begin
                        n_state = S_PROMPT;
                        n_pos   = '0;
                    end else begin
                        n_idx   = idx_inc;
                        n_state = S_LREAD;
                    end
                end
            end
            S_PROMPT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out       = '{dest: DEST_ECHO, data: PROMPT_BYTES[r_pos],
                                    line_end: 1'b0, run_last: (r_pos == PROMPT_LAST)};
                    if (r_pos == PROMPT_LAST) begin
                        n_fill  = '0;
                        n_state = S_IDLE;
                    end else begin
                        n_pos = r_pos + 3'd1;
                    end
                end
            end
            S_ERASE: begin
                // backspace, space, backspace
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out       = '{dest: DEST_ECHO,
                                    data: (r_pos == 3'd1) ? CH_SPACE : CH_BS,
                                    line_end: 1'b0, run_last: (r_pos == 3'd2)};
                    if (r_pos == 3'd2) begin
                        n_state = S_IDLE;
                    end else begin
                        n_pos = r_pos + 3'd1;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pos       <= '0;
            r_idx       <= '0;
            r_fill      <= '0;
            r_prev      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pos       <= n_pos;
            r_idx       <= n_idx;
            r_fill      <= n_fill;
            r_prev      <= n_prev;
            r_out_valid <= n_out_valid;
        end
        r_byte <= n_byte;
        r_out  <= n_out;
    end

    assign m_axis_tvalid   = r_out_valid;
    assign m_axis_tdata    = r_out.data;
    assign m_axis_tuser[0] = r_out.dest;
    assign m_axis_tuser[1] = r_out.line_end;
    assign m_axis_tlast    = r_out.run_last;

`ifndef NO_ASSERTIONS
    // the stored count never passes the line size
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FILL_MAX)
        else $error("fill count above line size");

    // line_end only ever marks a line word
    a_end_is_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tuser[0])
        else $error("line_end on an echo word");

    // a line word is never the last word of a run, the prompt follows it
    a_line_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> !m_axis_tlast)
        else $error("run ends on a line word");

    // after the last prompt word the line is empty again
    a_prompt_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_PROMPT && r_pos == PROMPT_LAST && out_free |=> r_fill == '0)
        else $error("line not cleared after prompt");
`endif

endmodule

/* tb/sv/serial_line_editor_tb.sv */
// testbench for the serial line editor: a directed byte list, then random terminal traffic
`timescale 1ns / 1ps

// Bytes go in on the slave stream in bursts with random gaps. Every accepted
// byte is run through an editor kept inside the bench, which holds its own
// copy of the line buffer, fill count and last kept byte. The words it
// predicts are queued, and each word taken from the master stream is checked
// field by field against the oldest queued word. A few directed rows carry a
// typed expectation instead: silent bytes, a plain echo of the byte itself,
// and the CR LF prompt answer to an empty line. The receiver stalls in
// changing patterns and once holds off long enough for the block to back up
// onto its input.
module serial_line_editor_tb;

    import sle_pkg::*;

    localparam int LINE_MAX      = 32;
    localparam int RANDOM_ACTIVE = 285;        // random bytes that must cause words
    localparam int MAX_CYCLES    = 1_000_000;
    localparam int LONG_HOLD     = 600;        // receiver hold-off, in cycles
    localparam int DRAIN_CYCLES  = 150;
    localparam int REPORT_MAX    = 10;

    // how the words of one directed byte are worked out
    typedef enum logic [1:0] {
        EXP_FROM_EDIT,     // by the bench editor
        EXP_SILENT,        // no word at all
        EXP_ECHO_SELF,     // one echo word holding the byte itself
        EXP_EMPTY_LINE     // CR, LF and the prompt
    } t_exp;

    typedef struct packed {
        logic [7:0] rx;
        t_exp       check;
    } t_dir_row;

    localparam int DIR_N = 24;
    localparam t_dir_row DIRECTED [DIR_N] = '{
        '{CH_BS,    EXP_SILENT},      // erase on an empty line
        '{CH_DEL,   EXP_SILENT},
        '{CH_CR,    EXP_EMPTY_LINE},
        '{CH_LF,    EXP_SILENT},      // lf right after cr is dropped
        '{CH_LF,    EXP_SILENT},      // and leaves the last kept byte at cr
        '{CH_SPACE, EXP_ECHO_SELF},
        '{CH_TAB,   EXP_SILENT},      // tab after space is a second space
        '{8'h41,    EXP_ECHO_SELF},
        '{CH_TAB,   EXP_FROM_EDIT},   // echoed as a space
        '{CH_TILDE, EXP_ECHO_SELF},
        '{8'h80,    EXP_SILENT},
        '{8'hFF,    EXP_SILENT},
        '{8'h00,    EXP_SILENT},
        '{CH_DEL,   EXP_FROM_EDIT},
        '{CH_BS,    EXP_FROM_EDIT},
        '{8'h21,    EXP_ECHO_SELF},
        '{CH_LF,    EXP_FROM_EDIT},   // lf alone ends a line
        '{CH_CR,    EXP_EMPTY_LINE},
        '{CH_LF,    EXP_SILENT},
        '{8'h1B,    EXP_SILENT},
        '{CH_SPACE, EXP_ECHO_SELF},   // space after an ignored control
        '{CH_SPACE, EXP_SILENT},
        '{CH_LF,    EXP_FROM_EDIT},   // line of one space
        '{8'h1F,    EXP_SILENT}
    };

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata = 8'h00;    // [7:0] rx_byte
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;            // [7:0] data_byte
    logic [1:0] m_axis_tuser;            // [0] destination, [1] line_end
    logic       m_axis_tlast;            // run_last

    serial_line_editor #(
        .LINE_MAX(LINE_MAX)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .m_axis_tlast (m_axis_tlast)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // bench copy of the editor state
    logic [7:0] line_buf [LINE_MAX];
    logic [5:0] line_fill = '0;
    logic [7:0] last_kept = '0;

    t_out_word words_due [$];    // words the block still owes, oldest first
    t_exp      kinds_sent [$];   // expectation kind per offered byte
    t_out_word run_words [$];

    int faults = 0;
    int bytes_taken = 0;
    int active_taken = 0;
    int words_seen = 0;
    int lines_handed = 0;
    int longest_line = 0;
    int erases = 0;
    int full_echoes = 0;
    int long_holds = 0;
    int cycles = 0;
    int burst_left = 0;

    function automatic void add_word(ref t_out_word q[$], input logic d,
                                     input logic [7:0] b, input logic e, input logic l);
        t_out_word w;
        w.dest     = d;
        w.data     = b;
        w.line_end = e;
        w.run_last = l;
        q.push_back(w);
    endfunction

    // one received byte through the line editor, words appended to q
    task automatic edit_and_echo(input logic [7:0] rx, ref t_out_word q[$]);
        logic [7:0] c;
        int i;
        c = (rx == CH_TAB) ? CH_SPACE : rx;
        if (c == CH_LF && last_kept == CH_CR)
            return;
        if (c == CH_CR || c == CH_LF) begin
            add_word(q, DEST_ECHO, CH_CR, 1'b0, 1'b0);
            add_word(q, DEST_ECHO, CH_LF, 1'b0, 1'b0);
            for (i = 0; i < line_fill; i++)
                add_word(q, DEST_LINE, line_buf[i], (i + 1 == line_fill), 1'b0);
            for (i = 0; i < PROMPT_LEN; i++)
                add_word(q, DEST_ECHO, PROMPT_BYTES[i], 1'b0, 1'b0);
            if (line_fill != 0)
                lines_handed++;
            if (line_fill > longest_line)
                longest_line = line_fill;
            line_fill = '0;
        end else if (c >= CH_SPACE && c <= CH_TILDE
                     && !(last_kept == CH_SPACE && c == CH_SPACE)) begin
            add_word(q, DEST_ECHO, c, 1'b0, 1'b0);
            if (line_fill < LINE_MAX) begin
                line_buf[line_fill] = c;
                line_fill = line_fill + 6'd1;
            end else begin
                full_echoes++;
            end
        end else if ((c == CH_BS || c == CH_DEL) && line_fill != 0) begin
            line_fill = line_fill - 6'd1;
            erases++;
            add_word(q, DEST_ECHO, CH_BS, 1'b0, 1'b0);
            add_word(q, DEST_ECHO, CH_SPACE, 1'b0, 1'b0);
            add_word(q, DEST_ECHO, CH_BS, 1'b0, 1'b0);
        end
        last_kept = c;
        if (q.size() > 0)
            q[q.size() - 1].run_last = 1'b1;
    endtask

    task automatic report_fault(input string what, input t_out_word want,
                                input t_out_word got);
        faults++;
        if (faults <= REPORT_MAX)
            $display("word %0d %s: want dest=%0b data=%02h end=%0b last=%0b",
                     words_seen, what, want.dest, want.data, want.line_end,
                     want.run_last,
                     ", got dest=%0b data=%02h end=%0b last=%0b",
                     got.dest, got.data, got.line_end, got.run_last);
    endtask

    // offer one byte; called and returns at a falling edge
    task automatic send_byte(input logic [7:0] b, input t_exp kind);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
        kinds_sent.push_back(kind);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
    endtask

    function automatic logic [7:0] line_char();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return 8'($urandom_range(8'h21, 8'h7E));
        else if (r < 85)
            return $urandom_range(0, 1) ? CH_SPACE : CH_TAB;
        else if (r < 93)
            return $urandom_range(0, 1) ? CH_BS : CH_DEL;
        return 8'($urandom_range(0, 255));
    endfunction

    // mostly whole lines with random content, the rest erase runs and noise
    task automatic send_random_sequence();
        int pick, len, i;
        pick = $urandom_range(0, 99);
        if (pick < 72) begin
            len = ($urandom_range(0, 6) == 0) ? $urandom_range(28, 40) : $urandom_range(0, 12);
            for (i = 0; i < len; i++)
                send_byte(line_char(), EXP_FROM_EDIT);
            case ($urandom_range(0, 3))
                0: send_byte(CH_CR, EXP_FROM_EDIT);
                1: send_byte(CH_LF, EXP_FROM_EDIT);
                2: begin
                    send_byte(CH_CR, EXP_FROM_EDIT);
                    send_byte(CH_LF, EXP_FROM_EDIT);
                end
                default: begin
                    send_byte(CH_LF, EXP_FROM_EDIT);
                    send_byte(CH_CR, EXP_FROM_EDIT);
                end
            endcase
        end else if (pick < 85) begin
            repeat ($urandom_range(1, 8))
                send_byte($urandom_range(0, 1) ? CH_BS : CH_DEL, EXP_FROM_EDIT);
        end else begin
            repeat ($urandom_range(1, 6))
                send_byte(8'($urandom_range(0, 255)), EXP_FROM_EDIT);
        end
    endtask

    // input side feeds the editor, output side is checked, in one process
    always @(posedge i_clk) begin
        t_out_word got;
        t_out_word want;
        t_exp k;
        int i;
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                k = kinds_sent.pop_front();
                run_words.delete();
                edit_and_echo(s_axis_tdata, run_words);
                bytes_taken++;
                if (run_words.size() > 0)
                    active_taken++;
                case (k)
                    EXP_FROM_EDIT: begin
                        foreach (run_words[j])
                            words_due.push_back(run_words[j]);
                    end
                    EXP_ECHO_SELF: add_word(words_due, DEST_ECHO, s_axis_tdata, 1'b0, 1'b1);
                    EXP_EMPTY_LINE: begin
                        add_word(words_due, DEST_ECHO, CH_CR, 1'b0, 1'b0);
                        add_word(words_due, DEST_ECHO, CH_LF, 1'b0, 1'b0);
                        for (i = 0; i < PROMPT_LEN; i++)
                            add_word(words_due, DEST_ECHO, PROMPT_BYTES[i], 1'b0,
                                     (i == PROMPT_LEN - 1));
                    end
                    default: ;
                endcase
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got.dest     = m_axis_tuser[0];
                got.data     = m_axis_tdata;
                got.line_end = m_axis_tuser[1];
                got.run_last = m_axis_tlast;
                words_seen++;
                if (words_due.size() == 0) begin
                    report_fault("not due", got, got);
                end else begin
                    want = words_due.pop_front();
                    if (want.dest != got.dest || want.data != got.data
                        || want.line_end != got.line_end || want.run_last != got.run_last)
                        report_fault("mismatch", want, got);
                end
            end
        end
    end

    // receiver: stall patterns in stretches, plus one long hold-off
    initial begin
        int mode;
        int mode_left;
        int hold_left;
        int tick;
        bit hold_done;
        logic rdy;
        mode = 0;
        mode_left = 0;
        hold_left = 0;
        tick = 0;
        hold_done = 1'b0;
        wait (i_rst_n);
        forever begin
            @(negedge i_clk);
            tick++;
            if (hold_left > 0) begin
                hold_left--;
                rdy = 1'b0;
            end else if (!hold_done && bytes_taken >= 60) begin
                hold_done = 1'b1;
                hold_left = LONG_HOLD - 1;
                long_holds++;
                rdy = 1'b0;
            end else begin
                if (mode_left == 0) begin
                    mode = $urandom_range(0, 3);
                    mode_left = $urandom_range(16, 160);
                end
                mode_left--;
                case (mode)
                    0: rdy = 1'b1;
                    1: rdy = 1'($urandom_range(0, 1));
                    2: rdy = (tick % 5) < 3;
                    default: rdy = ($urandom_range(0, 5) == 0);
                endcase
            end
            m_axis_tready <= rdy;
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > MAX_CYCLES) begin
            $display("timed out after %0d cycles, %0d words still due",
                     cycles, words_due.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        int i;
        int active_base;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        for (i = 0; i < DIR_N; i++)
            send_byte(DIRECTED[i].rx, DIRECTED[i].check);
        active_base = active_taken;
        while (active_taken < active_base + RANDOM_ACTIVE)
            send_random_sequence();
        s_axis_tvalid <= 1'b0;
        while (words_due.size() != 0 || kinds_sent.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("%0d bytes in (%0d with words), %0d words out, %0d lines up to %0d bytes",
                 bytes_taken, active_taken, words_seen, lines_handed, longest_line);
        $display("%0d erases, %0d echoes on a full line, %0d long hold-offs, %0d faults",
                 erases, full_echoes, long_holds, faults);
        if (faults == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

/* filelist.f */
sv/sle_pkg.sv
sv/sle_ram.sv
sv/serial_line_editor.sv
tb/sv/serial_line_editor_tb.sv
